@@ hdl/render_target_pool_allocator_top_defines.svh @@
// assertion macros shared by the render target pool allocator rtl
// no dependencies; included by files that carry assertions
`ifndef RENDER_TARGET_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define RENDER_TARGET_POOL_ALLOCATOR_TOP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define RTPA_ASSERT_IMP(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("rtpa assertion failed");

// condition holds in the cycle after the trigger
`define RTPA_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("rtpa assertion failed");

`endif

@@ hdl/rtpa_pkg.sv @@
// types, codes and helper functions of the render target pool allocator
// no dependencies; used by rtpa_slot_mem, rtpa_fit_unit and the top through scoped names
package rtpa_pkg;

   localparam int SCORE_W = 14;

   localparam logic [1:0] OP_ACQUIRE = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_CLEANUP = 2'd2;

   typedef enum logic [2:0] {
      STAT_EXACT    = 3'd0,
      STAT_RESCORED = 3'd1,
      STAT_NEW      = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_DONE     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXPIRE,
      ST_EVALL,
      ST_GRANT,
      ST_RESP
   } state_type;

   // stored slot descriptor, mips is the effective level count
   typedef struct packed {
      logic [14:0] width;
      logic [14:0] height;
      logic [3:0]  mips;
      logic [7:0]  format;
      logic [7:0]  usage;
      logic [11:0] layers;
      logic [31:0] sampler;
   } desc_type;

   // result of comparing one stored descriptor with the request
   typedef struct packed {
      logic                      exact;
      logic signed [SCORE_W-1:0] score;
   } fit_type;

   // effective mip count of a request
   function automatic logic [3:0] derive_mips(logic [3:0] mreq, logic full,
                                              logic [14:0] w, logic [14:0] h);
      logic [14:0] m;
      logic [3:0]  n;
      m = (w > h) ? w : h;
      n = 4'd0;
      for (int i = 1; i < 15; i++) begin
         if (m[i]) n = 4'(i);
      end
      if (mreq != 4'd0) return mreq;
      if (!full) return 4'd1;
      return n + 4'd1;
   endfunction

endpackage

@@ hdl/rtpa_req_if.sv @@
// request channel of the render target pool allocator
// no dependencies; plain valid/ready channel
interface rtpa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [14:0] width;
   logic [14:0] height;
   logic [3:0]  mip_request;
   logic        requires_mips;
   logic [7:0]  pixel_format;
   logic [7:0]  usage_mask;
   logic [11:0] array_layers;
   logic [31:0] sampler_state;
   logic [4:0]  release_slot;
   logic [31:0] frame;

   modport source (output valid, opcode, width, height, mip_request, requires_mips,
                   pixel_format, usage_mask, array_layers, sampler_state,
                   release_slot, frame, input ready);
   modport sink (input valid, opcode, width, height, mip_request, requires_mips,
                 pixel_format, usage_mask, array_layers, sampler_state,
                 release_slot, frame, output ready);
endinterface

@@ hdl/rtpa_rsp_if.sv @@
// response channel of the render target pool allocator
// no dependencies; plain valid/ready channel
interface rtpa_rsp_if;
   logic              valid;
   logic              ready;
   logic [4:0]        slot;
   logic [2:0]        status;
   logic signed [5:0] fit_score;

   modport source (output valid, slot, status, fit_score, input ready);
   modport sink (input valid, slot, status, fit_score, output ready);
endinterface

@@ hdl/rtpa_slot_mem.sv @@
// slot descriptor and last-frame storage, one write and one read port
// depends on rtpa_pkg for the descriptor type
module rtpa_slot_mem #(
   parameter int SLOTS = 32,
   parameter int IW    = 5
) (
   input  logic              clock,
   input  logic [IW-1:0]     rd_addr,
   output rtpa_pkg::desc_type desc_rd,
   output logic [31:0]       frame_rd,
   input  logic [IW-1:0]     wr_addr,
   input  logic              desc_we,
   input  rtpa_pkg::desc_type desc_wdata,
   input  logic              frame_we,
   input  logic [31:0]       frame_wdata
);

   rtpa_pkg::desc_type desc_mem [SLOTS];
   logic [31:0]        frame_mem [SLOTS];

   // write port
   always_ff @(posedge clock) begin
      if (desc_we) desc_mem[wr_addr] <= desc_wdata;
      if (frame_we) frame_mem[wr_addr] <= frame_wdata;
   end

   // registered read port
   always_ff @(posedge clock) begin
      desc_rd  <= desc_mem[rd_addr];
      frame_rd <= frame_mem[rd_addr];
   end

endmodule

@@ hdl/rtpa_fit_unit.sv @@
// shared compare unit: exact match and fit score of one slot against the request
// depends on rtpa_pkg for descriptor and result types
module rtpa_fit_unit (
   input  rtpa_pkg::desc_type stored,
   input  rtpa_pkg::desc_type request,
   output rtpa_pkg::fit_type  result
);

   logic                                use_ok, size_ok, lay_ok, mip_ok, fmt_ok;
   logic [11:0]                         ldiff;
   logic [3:0]                          mdiff;
   logic signed [rtpa_pkg::SCORE_W-1:0] uterm, lterm, mterm;

   // qualifying checks
   always_comb begin
      use_ok  = (stored.usage & request.usage) != 8'd0;
      size_ok = (stored.width == request.width) && (stored.height == request.height);
      lay_ok  = stored.layers >= request.layers;
      mip_ok  = stored.mips >= request.mips;
      fmt_ok  = stored.format == request.format;
   end

   // score terms
   always_comb begin
      ldiff = stored.layers - request.layers;
      mdiff = stored.mips - request.mips;
      uterm = (stored.usage == request.usage) ? 14'sd5 : 14'sd0;
      lterm = (ldiff != 12'd0) ? (14'sd5 - $signed({2'b00, ldiff})) : 14'sd0;
      mterm = (mdiff <= 4'd9) ? (14'sd10 - $signed({10'd0, mdiff})) : 14'sd1;
   end

   // result
   always_comb begin
      result.exact = (stored == request);
      if (use_ok && size_ok && lay_ok && mip_ok && fmt_ok) begin
         result.score = uterm + lterm + mterm;
      end else begin
         result.score = -14'sd1;
      end
   end

endmodule

@@ hdl/render_target_pool_allocator_top.sv @@
// Render target pool allocator. Acquire scans every slot once through the
// descriptor memory (one slot per cycle, behind its registered read port); when
// no slot matches, fits or is free, it adds an expiry pass over the last-frame
// memory and possibly an evict-all pass. Cleanup runs the expiry pass alone;
// release and unknown opcodes go straight to the response. One item is in work
// at a time; a new request is taken while the previous response still waits.
// The slot memories need no clearing after reset: valid bits guard them.
// depends on rtpa_pkg, rtpa_req_if, rtpa_rsp_if, rtpa_slot_mem, rtpa_fit_unit
`include "render_target_pool_allocator_top_defines.svh"

module render_target_pool_allocator_top #(
   parameter int SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   rtpa_req_if.sink    req_chan,
   rtpa_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] LAST = CW'(SLOTS);

   rtpa_pkg::state_type state_ff, state_in;

   logic [15:0]        life_ff;
   logic [SLOTS-1:0]   valid_ff, busy_ff;
   logic [1:0]         op_ff;
   rtpa_pkg::desc_type rq_ff;
   logic [31:0]        frame_ff;
   logic [CW-1:0]      cnt_ff;
   logic               pv_ff;
   logic [IW-1:0]      pidx_ff;
   logic               ex_found_ff, fr_found_ff;
   logic [IW-1:0]      ex_idx_ff, best_idx_ff, fr_idx_ff, pick_ff;
   logic signed [5:0]  best_ff;
   logic [4:0]         res_slot_ff;
   rtpa_pkg::status_type res_stat_ff;
   logic signed [5:0]  res_fit_ff;
   logic               rsp_vld_ff;
   logic [4:0]         rsp_slot_ff;
   logic [2:0]         rsp_stat_ff;
   logic signed [5:0]  rsp_fit_ff;

   rtpa_pkg::desc_type req_desc, mem_desc;
   rtpa_pkg::fit_type  fit;
   logic [31:0]        mem_frame;
   logic [IW-1:0]      rd_addr, wr_addr, rel_idx, cidx;
   logic               desc_we, frame_we;
   logic [31:0]        frame_wdata;
   logic               req_ready, accept, scan_end, rel_ok, expired, cand;
   logic               rsp_free;

   // request descriptor with effective mip count
   always_comb begin
      req_desc.width   = req_chan.width;
      req_desc.height  = req_chan.height;
      req_desc.mips    = rtpa_pkg::derive_mips(req_chan.mip_request, req_chan.requires_mips,
                                               req_chan.width, req_chan.height);
      req_desc.format  = req_chan.pixel_format;
      req_desc.usage   = req_chan.usage_mask;
      req_desc.layers  = req_chan.array_layers;
      req_desc.sampler = req_chan.sampler_state;
   end

   // misc decode
   always_comb begin
      accept   = req_chan.valid && req_ready;
      rel_idx  = IW'(req_chan.release_slot);
      rel_ok   = ({27'd0, req_chan.release_slot} < 32'(SLOTS)) && valid_ff[rel_idx];
      scan_end = (cnt_ff == LAST) && !pv_ff;
      cidx     = cnt_ff[IW-1:0];
      cand     = valid_ff[pidx_ff] && !busy_ff[pidx_ff];
      expired  = (frame_ff - mem_frame) > {16'd0, life_ff};
      rsp_free = !rsp_vld_ff || rsp_chan.ready;
   end

   rtpa_slot_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
      .clock       (clock),
      .rd_addr     (rd_addr),
      .desc_rd     (mem_desc),
      .frame_rd    (mem_frame),
      .wr_addr     (wr_addr),
      .desc_we     (desc_we),
      .desc_wdata  (rq_ff),
      .frame_we    (frame_we),
      .frame_wdata (frame_wdata)
   );

   rtpa_fit_unit u_fit (
      .stored  (mem_desc),
      .request (rq_ff),
      .result  (fit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtpa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_chan.opcode == rtpa_pkg::OP_ACQUIRE) state_in = rtpa_pkg::ST_SCAN;
               else if (req_chan.opcode == rtpa_pkg::OP_CLEANUP)
                  state_in = rtpa_pkg::ST_EXPIRE;
               else state_in = rtpa_pkg::ST_RESP;
            end
         end
         rtpa_pkg::ST_SCAN: begin
            if (scan_end) begin
               if (ex_found_ff || (best_ff != -6'sd1) || fr_found_ff)
                  state_in = rtpa_pkg::ST_GRANT;
               else state_in = rtpa_pkg::ST_EXPIRE;
            end
         end
         rtpa_pkg::ST_EXPIRE: begin
            if (scan_end) begin
               if (op_ff == rtpa_pkg::OP_CLEANUP) state_in = rtpa_pkg::ST_RESP;
               else if (fr_found_ff) state_in = rtpa_pkg::ST_GRANT;
               else state_in = rtpa_pkg::ST_EVALL;
            end
         end
         rtpa_pkg::ST_EVALL: begin
            if (cnt_ff == LAST) begin
               state_in = fr_found_ff ? rtpa_pkg::ST_GRANT : rtpa_pkg::ST_RESP;
            end
         end
         rtpa_pkg::ST_GRANT: state_in = rtpa_pkg::ST_RESP;
         rtpa_pkg::ST_RESP: begin
            if (rsp_free) state_in = rtpa_pkg::ST_IDLE;
         end
         default: state_in = rtpa_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer: ready and memory controls
   always_comb begin
      req_ready   = 1'b0;
      desc_we     = 1'b0;
      frame_we    = 1'b0;
      wr_addr     = pick_ff;
      frame_wdata = frame_ff;
      rd_addr     = cidx;
      unique case (state_ff)
         rtpa_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            wr_addr     = rel_idx;
            frame_wdata = req_chan.frame;
            frame_we    = req_chan.valid && (req_chan.opcode == rtpa_pkg::OP_RELEASE)
                          && rel_ok;
         end
         rtpa_pkg::ST_GRANT: begin
            desc_we  = 1'b1;
            frame_we = 1'b1;
         end
         default: begin
            desc_we = 1'b0;
         end
      endcase
   end

   // sequencer state and configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtpa_pkg::ST_IDLE;
         life_ff  <= 16'd3;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) life_ff <= csr_wr_data;
      end
   end

   // slot valid and busy bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff  <= '0;
      end else begin
         unique case (state_ff)
            rtpa_pkg::ST_IDLE: begin
               if (accept && (req_chan.opcode == rtpa_pkg::OP_RELEASE) && rel_ok)
                  busy_ff[rel_idx] <= 1'b0;
            end
            rtpa_pkg::ST_EXPIRE: begin
               if (pv_ff && cand && expired) valid_ff[pidx_ff] <= 1'b0;
            end
            rtpa_pkg::ST_EVALL: begin
               if ((cnt_ff != LAST) && valid_ff[cidx] && !busy_ff[cidx])
                  valid_ff[cidx] <= 1'b0;
            end
            rtpa_pkg::ST_GRANT: begin
               valid_ff[pick_ff] <= 1'b1;
               busy_ff[pick_ff]  <= 1'b1;
            end
            default: begin
               valid_ff <= valid_ff;
            end
         endcase
      end
   end

   // scan counters and item bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pv_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            rtpa_pkg::ST_IDLE: begin
               cnt_ff <= '0;
               pv_ff  <= 1'b0;
            end
            rtpa_pkg::ST_SCAN, rtpa_pkg::ST_EXPIRE: begin
               if (scan_end) begin
                  cnt_ff <= '0;
               end else if (cnt_ff != LAST) begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
               pv_ff <= (cnt_ff != LAST);
            end
            rtpa_pkg::ST_EVALL: begin
               if (cnt_ff != LAST) cnt_ff <= cnt_ff + CW'(1);
               pv_ff <= 1'b0;
            end
            default: begin
               pv_ff <= 1'b0;
            end
         endcase
      end
   end

   // request hold, search results and pending result
   always_ff @(posedge clock) begin
      pidx_ff <= cidx;
      unique case (state_ff)
         rtpa_pkg::ST_IDLE: begin
            op_ff       <= req_chan.opcode;
            rq_ff       <= req_desc;
            frame_ff    <= req_chan.frame;
            ex_found_ff <= 1'b0;
            fr_found_ff <= 1'b0;
            best_ff     <= -6'sd1;
            res_fit_ff  <= -6'sd1;
            res_stat_ff <= rtpa_pkg::STAT_DONE;
            res_slot_ff <= (req_chan.opcode == rtpa_pkg::OP_RELEASE)
                           ? req_chan.release_slot : 5'd0;
         end
         rtpa_pkg::ST_SCAN: begin
            if (pv_ff) begin
               if (cand) begin
                  if (fit.exact && !ex_found_ff) begin
                     ex_found_ff <= 1'b1;
                     ex_idx_ff   <= pidx_ff;
                  end
                  if (fit.score > $signed({{(rtpa_pkg::SCORE_W-6){best_ff[5]}}, best_ff}))
                  begin
                     best_ff     <= 6'(fit.score);
                     best_idx_ff <= pidx_ff;
                  end
               end else if (!valid_ff[pidx_ff] && !fr_found_ff) begin
                  fr_found_ff <= 1'b1;
                  fr_idx_ff   <= pidx_ff;
               end
            end
            if (scan_end) begin
               if (ex_found_ff) begin
                  pick_ff     <= ex_idx_ff;
                  res_stat_ff <= rtpa_pkg::STAT_EXACT;
               end else if (best_ff != -6'sd1) begin
                  pick_ff     <= best_idx_ff;
                  res_stat_ff <= rtpa_pkg::STAT_RESCORED;
                  res_fit_ff  <= best_ff;
               end else begin
                  pick_ff     <= fr_idx_ff;
                  res_stat_ff <= rtpa_pkg::STAT_NEW;
               end
            end
         end
         rtpa_pkg::ST_EXPIRE: begin
            if (pv_ff && cand && expired && !fr_found_ff) begin
               fr_found_ff <= 1'b1;
               fr_idx_ff   <= pidx_ff;
            end
            if (scan_end) begin
               pick_ff     <= fr_idx_ff;
               res_stat_ff <= (op_ff == rtpa_pkg::OP_CLEANUP) ? rtpa_pkg::STAT_DONE
                                                               : rtpa_pkg::STAT_NEW;
            end
         end
         rtpa_pkg::ST_EVALL: begin
            if ((cnt_ff != LAST) && valid_ff[cidx] && !busy_ff[cidx] && !fr_found_ff) begin
               fr_found_ff <= 1'b1;
               fr_idx_ff   <= cidx;
            end
            if (cnt_ff == LAST) begin
               pick_ff     <= fr_idx_ff;
               res_stat_ff <= fr_found_ff ? rtpa_pkg::STAT_NEW : rtpa_pkg::STAT_FULL;
            end
         end
         rtpa_pkg::ST_GRANT: begin
            res_slot_ff <= 5'(pick_ff);
         end
         default: begin
            op_ff <= op_ff;
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if ((state_ff == rtpa_pkg::ST_RESP) && rsp_free) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == rtpa_pkg::ST_RESP) && rsp_free) begin
         rsp_slot_ff <= res_slot_ff;
         rsp_stat_ff <= res_stat_ff;
         rsp_fit_ff  <= res_fit_ff;
      end
   end

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.slot      = rsp_slot_ff;
   assign rsp_chan.status    = rsp_stat_ff;
   assign rsp_chan.fit_score = rsp_fit_ff;

   // a busy slot is always a valid slot
   `RTPA_ASSERT_IMP(a_busy_valid, clock, reset, 1'b1, ((busy_ff & ~valid_ff) == '0))
   // a grant leaves the picked slot valid and busy
   `RTPA_ASSERT_NEXT(a_grant_marks, clock, reset, (state_ff == rtpa_pkg::ST_GRANT),
      (valid_ff[pick_ff] && busy_ff[pick_ff]))
   // only rescored reuse carries a real fit score
   `RTPA_ASSERT_IMP(a_fit_code, clock, reset,
      (rsp_vld_ff && (rsp_stat_ff != rtpa_pkg::STAT_RESCORED)), (rsp_fit_ff == -6'sd1))
   // a rescored reuse score is never negative
   `RTPA_ASSERT_IMP(a_fit_pos, clock, reset,
      (rsp_vld_ff && (rsp_stat_ff == rtpa_pkg::STAT_RESCORED)), (!rsp_fit_ff[5]))

endmodule
